FILE: rtl/ccts_pkg.sv
// Shared types, constants and byte classification for the camel case token splitter.
package ccts_pkg;

	localparam int SEG_LIMIT   = 256;
	localparam int SEG_LEN_W   = $clog2(SEG_LIMIT + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CHAR_UC_A   = 8'h41;
	localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
	localparam logic [7:0] CHAR_LC_A   = 8'h61;
	localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
	localparam logic [7:0] CHAR_DIG_0  = 8'h30;
	localparam logic [7:0] CHAR_DIG_9  = 8'h39;
	localparam logic [7:0] CASE_FOLD   = 8'h20;

	typedef enum logic [1:0] {
		CLS_UPPER = 2'd0,
		CLS_LOWER = 2'd1,
		CLS_DIGIT = 2'd2,
		CLS_OTHER = 2'd3
	} cls_t;

	// One result to be emitted, as seen by the front end.
	typedef struct packed {
		logic [7:0] low_byte;
		logic       first;
		logic       seg;
		logic       non_ascii;
		logic       done;
	} slot_t;

	// One queue entry: the results of one input transfer (one or two).
	typedef struct packed {
		slot_t       a;
		slot_t       b;
		logic        has_b;
		logic [31:0] base;
	} rec_t;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		if (b >= CHAR_UC_A && b <= CHAR_UC_Z) begin
			c = CLS_UPPER;
		end else if (b >= CHAR_LC_A && b <= CHAR_LC_Z) begin
			c = CLS_LOWER;
		end else if (b >= CHAR_DIG_0 && b <= CHAR_DIG_9) begin
			c = CLS_DIGIT;
		end else begin
			c = CLS_OTHER;
		end
		return c;
	endfunction

	function automatic logic [7:0] fold_lower(input logic [7:0] b);
		logic [7:0] r;
		r = (classify(b) == CLS_UPPER) ? b + CASE_FOLD : b;
		return r;
	endfunction

	function automatic logic split_before(input cls_t p, input cls_t c,
			input logic has_next, input cls_t nx);
		logic s;
		s = 1'b0;
		if (p == CLS_LOWER && c == CLS_UPPER) begin
			s = 1'b1;
		end
		if (p == CLS_UPPER && c == CLS_UPPER && has_next && nx == CLS_LOWER) begin
			s = 1'b1;
		end
		if ((p == CLS_UPPER || p == CLS_LOWER) && c == CLS_DIGIT) begin
			s = 1'b1;
		end
		if (p == CLS_DIGIT && (c == CLS_UPPER || c == CLS_LOWER)) begin
			s = 1'b1;
		end
		return s;
	endfunction

endpackage

FILE: rtl/ccts_front.sv
// Front end: accepts token bytes, holds one byte of lookahead and classifies boundaries.
module ccts_front import ccts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic [31:0] token_base,
	input  logic        last_byte,
	input  logic        q_full,
	output logic        push,
	output rec_t        push_rec
);

	logic [7:0]  pend_q;
	logic        pend_valid_q;
	logic        pend_first_q;
	cls_t        prev_cls_q;
	logic [31:0] base_q;

	logic accept;
	cls_t cls_in;
	cls_t cls_pend;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign cls_in   = classify(text_byte);
	assign cls_pend = classify(pend_q);
	assign push     = accept && (pend_valid_q || last_byte);

	always_comb begin
		push_rec = '0;
		// later bytes of a token carry no offset of their own
		push_rec.base = pend_valid_q ? base_q : token_base;
		if (!pend_valid_q) begin
			// single-byte token: emit at once
			push_rec.a.low_byte  = fold_lower(text_byte);
			push_rec.a.first     = 1'b1;
			push_rec.a.seg       = 1'b1;
			push_rec.a.non_ascii = (text_byte >= ASCII_LIMIT);
			push_rec.a.done      = 1'b1;
			push_rec.has_b       = 1'b0;
		end else begin
			push_rec.a.low_byte  = fold_lower(pend_q);
			push_rec.a.first     = pend_first_q;
			push_rec.a.seg       = pend_first_q ||
				split_before(prev_cls_q, cls_pend, 1'b1, cls_in);
			push_rec.a.non_ascii = (pend_q >= ASCII_LIMIT);
			push_rec.a.done      = 1'b0;
			push_rec.has_b       = last_byte;
		end
		// final byte has no lookahead
		push_rec.b.low_byte  = fold_lower(text_byte);
		push_rec.b.first     = 1'b0;
		push_rec.b.seg       = split_before(cls_pend, cls_in, 1'b0, CLS_OTHER);
		push_rec.b.non_ascii = (text_byte >= ASCII_LIMIT);
		push_rec.b.done      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_first_q <= 1'b0;
			prev_cls_q   <= CLS_OTHER;
			base_q       <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pend_q       <= '0;
				pend_valid_q <= 1'b0;
				pend_first_q <= 1'b0;
				prev_cls_q   <= CLS_OTHER;
			end else begin
				pend_q       <= text_byte;
				pend_valid_q <= 1'b1;
				pend_first_q <= !pend_valid_q;
				prev_cls_q   <= pend_valid_q ? cls_pend : CLS_OTHER;
				// hold the token offset from its first byte
				if (!pend_valid_q) begin
					base_q <= token_base;
				end
			end
		end
	end

endmodule

FILE: rtl/ccts_queue.sv
// Short queue of per-transfer result records between front and back end.
module ccts_queue import ccts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	output logic head_valid,
	output rec_t head_rec,
	input  logic pop
);

	rec_t                   mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	logic do_pop;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = mem[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/ccts_back.sv
// Back end: tracks offsets, segment length and token validity, drives the result register.
module ccts_back import ccts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  rec_t        head_rec,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  low_byte,
	output logic [31:0] text_offset,
	output logic        segment_first,
	output logic        beyond_limit,
	output logic        token_done,
	output logic        split_ok
);

	logic                 half_q;
	logic [31:0]          off_q;
	logic [SEG_LEN_W-1:0] seglen_q;
	logic                 ascii_q;
	logic                 bound_q;
	logic                 out_valid_q;

	slot_t                slot;
	logic                 load;
	logic [31:0]          off_e;
	logic [SEG_LEN_W-1:0] seglen_e;
	logic                 ascii_e;
	logic                 bound_e;

	assign slot  = half_q ? head_rec.b : head_rec.a;
	assign load  = head_valid && (!out_valid_q || !out_stall);
	assign pop   = load && (half_q || !head_rec.has_b);

	// a token's first byte restarts all running state
	assign off_e    = slot.first ? head_rec.base : off_q;
	assign seglen_e = slot.seg ? '0 : seglen_q;
	assign ascii_e  = (slot.first || ascii_q) && !slot.non_ascii;
	assign bound_e  = !slot.first && (bound_q || slot.seg);

	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			low_byte      <= slot.low_byte;
			text_offset   <= off_e;
			segment_first <= slot.seg;
			beyond_limit  <= (seglen_e >= SEG_LEN_W'(SEG_LIMIT));
			token_done    <= slot.done;
			split_ok      <= slot.done && ascii_e && bound_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			off_q       <= '0;
			seglen_q    <= '0;
			ascii_q     <= 1'b1;
			bound_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				half_q   <= !pop;
				off_q    <= off_e + 32'd1;
				// saturate at the segment limit
				seglen_q <= (seglen_e < SEG_LEN_W'(SEG_LIMIT)) ? seglen_e + 1'b1 : seglen_e;
				ascii_q  <= ascii_e;
				bound_q  <= bound_e;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/camel_case_token_splitter.sv
// Camel case token splitter: one token byte per transfer in, one result per byte out.
// Takes one byte per cycle while in_stall is low. The result for a byte leaves once
// the next byte of its token is seen, so in a token of two or more bytes the first
// byte gives no result and the last gives two, and a single-byte token gives one;
// a token of n bytes gives n results, one per cycle from the back end's result
// register while out_stall is low. The token offset is taken from the token's first
// byte only. The front end classifies bytes and queues one record per input transfer
// that releases results in a four-entry queue; the back end emits a final byte's
// record as two results, while the first byte of a following token of two or more
// bytes adds no record. With no output stall, a released result passes the queue
// into the output register; a final byte's second result follows in the next cycle.
module camel_case_token_splitter import ccts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic [31:0] token_base,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  low_byte,
	output logic [31:0] text_offset,
	output logic        segment_first,
	output logic        beyond_limit,
	output logic        token_done,
	output logic        split_ok
);

	logic q_full;
	logic push;
	rec_t push_rec;
	logic head_valid;
	rec_t head_rec;
	logic pop;

	ccts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.token_base (token_base),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	ccts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop)
	);

	ccts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_rec      (head_rec),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.low_byte      (low_byte),
		.text_offset   (text_offset),
		.segment_first (segment_first),
		.beyond_limit  (beyond_limit),
		.token_done    (token_done),
		.split_ok      (split_ok)
	);

endmodule

FILE: sim/camel_case_token_splitter_tb.sv
// Self-checking testbench for the camel case token splitter: directed table, random tokens, predictor.
module camel_case_token_splitter_tb;
	import ccts_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int TARGET_BYTES = 1200;

	typedef struct {
		logic [7:0]  lb;
		logic [31:0] ofs;
		logic        seg;
		logic        over;
		logic        done;
		logic        ok;
	} split_res_t;

	typedef struct {
		logic [7:0]  b;
		logic [31:0] base;
		logic        last;
		bit          typed;
		split_res_t  want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = '0;
	logic [31:0] token_base = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  low_byte;
	logic [31:0] text_offset;
	logic        segment_first;
	logic        beyond_limit;
	logic        token_done;
	logic        split_ok;

	// typed expectation travelling with the current input row
	bit          row_typed = 1'b0;
	split_res_t  row_want;

	// predictor state
	logic [7:0]  held_byte = '0;
	bit          held_valid = 1'b0;
	bit          held_first = 1'b0;
	cls_t        prev_cls = CLS_OTHER;
	logic [31:0] byte_pos = '0;
	logic [31:0] tok_base = '0;
	int          seg_run = 0;
	bit          ascii_only = 1'b1;
	bit          split_seen = 1'b0;

	split_res_t  split_results_q[$];
	stim_row_t   stim_rows[$];

	int fails = 0;
	int bytes_in = 0;
	int tokens_sent = 0;
	int results_seen = 0;
	int saturated_seen = 0;
	int good_splits = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	int quiet_left = 0;
	int stall_left = 0;

	camel_case_token_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.token_base(token_base),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.low_byte(low_byte),
		.text_offset(text_offset),
		.segment_first(segment_first),
		.beyond_limit(beyond_limit),
		.token_done(token_done),
		.split_ok(split_ok)
	);

	always #5 clk = ~clk;

	function automatic void append_row(stim_row_t row);
		stim_rows = {stim_rows, row};
	endfunction

	function automatic cls_t char_kind(logic [7:0] b);
		if (b >= CHAR_UC_A && b <= CHAR_UC_Z) return CLS_UPPER;
		if (b >= CHAR_LC_A && b <= CHAR_LC_Z) return CLS_LOWER;
		if (b >= CHAR_DIG_0 && b <= CHAR_DIG_9) return CLS_DIGIT;
		return CLS_OTHER;
	endfunction

	function automatic bit starts_segment(cls_t p, cls_t c, bit has_next, cls_t nx);
		bit letter_p;
		bit letter_c;
		letter_p = (p == CLS_UPPER || p == CLS_LOWER);
		letter_c = (c == CLS_UPPER || c == CLS_LOWER);
		return (p == CLS_LOWER && c == CLS_UPPER)
			|| (p == CLS_UPPER && c == CLS_UPPER && has_next && nx == CLS_LOWER)
			|| (letter_p && c == CLS_DIGIT)
			|| (p == CLS_DIGIT && letter_c);
	endfunction

	function automatic void push_split_result(logic [7:0] b, bit first, bit has_next,
			cls_t nx, bit done);
		cls_t c;
		bit seg;
		split_res_t r;
		c = char_kind(b);
		seg = first;
		if (!first && starts_segment(prev_cls, c, has_next, nx)) begin
			seg = 1'b1;
			split_seen = 1'b1;
		end
		if (seg) seg_run = 0;
		if (b >= ASCII_LIMIT) ascii_only = 1'b0;
		r.lb = (c == CLS_UPPER) ? b + CASE_FOLD : b;
		r.ofs = tok_base + byte_pos;
		r.seg = seg;
		r.over = (seg_run >= SEG_LIMIT);
		r.done = done;
		r.ok = done && ascii_only && !first && split_seen;
		split_results_q = {split_results_q, r};
		if (seg_run < SEG_LIMIT) seg_run++;
		prev_cls = c;
		byte_pos = byte_pos + 32'd1;
	endfunction

	// Each byte but a token's last is held until its successor shows whether it starts a segment.
	function automatic void predict_split(logic [7:0] b, logic [31:0] base, bit last);
		if (!held_valid) begin
			tok_base = base;
			byte_pos = '0;
			seg_run = 0;
			ascii_only = 1'b1;
			split_seen = 1'b0;
			prev_cls = CLS_OTHER;
			if (last) begin
				push_split_result(b, 1'b1, 1'b0, CLS_OTHER, 1'b1);
			end else begin
				held_byte = b;
				held_valid = 1'b1;
				held_first = 1'b1;
			end
		end else begin
			push_split_result(held_byte, held_first, 1'b1, char_kind(b), 1'b0);
			if (last) begin
				push_split_result(b, 1'b0, 1'b0, CLS_OTHER, 1'b1);
				held_valid = 1'b0;
				held_first = 1'b0;
				held_byte = '0;
				prev_cls = CLS_OTHER;
			end else begin
				held_byte = b;
				held_first = 1'b0;
			end
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d: %s got %h want %h at %0t",
			results_seen, what, got, want, $realtime);
		fails++;
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_char(int mode);
		int r;
		if (mode == 1) return 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (mode == 2) begin
			// long runs: nearly all lower case so the segment counter saturates
			if (r < 2) return CHAR_UC_A + 8'($urandom_range(0, 25));
			return CHAR_LC_A + 8'($urandom_range(0, 25));
		end
		if (r < 40) return CHAR_LC_A + 8'($urandom_range(0, 25));
		if (r < 65) return CHAR_UC_A + 8'($urandom_range(0, 25));
		if (r < 80) return CHAR_DIG_0 + 8'($urandom_range(0, 9));
		if (r < 95) return 8'($urandom_range(0, 127));
		return 8'($urandom_range(128, 255));
	endfunction

	task automatic send_byte(logic [7:0] b, logic [31:0] base, bit last, bit typed,
			split_res_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		text_byte = b;
		token_base = base;
		last_byte = last;
		row_typed = typed;
		row_want = want;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_token(int len, int mode, logic [31:0] base);
		split_res_t none;
		none = '{default: '0};
		for (int i = 0; i < len; i++) begin
			// offset is only sampled on the first byte; scramble it elsewhere
			send_byte(pick_char(mode), (i == 0) ? base : $urandom, i == len - 1, 1'b0, none);
		end
		tokens_sent++;
	endtask

	// Output stall pattern: mostly short bursts, a few long holds.
	always @(negedge clk) begin
		int r;
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (quiet) begin
			out_stall = 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			out_stall = (r >= 65);
			if (r >= 97) stall_left = $urandom_range(10, 40);
			else if (r >= 65) stall_left = $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if (quiet_left == 0) begin
			quiet <= ($urandom_range(0, 3) == 0);
			quiet_left <= $urandom_range(50, 300);
		end else begin
			quiet_left <= quiet_left - 1;
		end
	end

	// Predict on accepted input, then check accepted output.
	always @(posedge clk) begin
		split_res_t want;
		if (arst_n && in_valid && !in_stall) begin
			predict_split(text_byte, token_base, last_byte);
			if (row_typed) begin
				split_results_q[$] = row_want;
			end
			bytes_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (split_results_q.size() == 0) begin
				report_mismatch("result with nothing expected, offset", text_offset, '0);
			end else begin
				want = split_results_q.pop_front();
				if (low_byte !== want.lb) report_mismatch("low_byte", low_byte, want.lb);
				if (text_offset !== want.ofs) report_mismatch("text_offset", text_offset, want.ofs);
				if (segment_first !== want.seg)
					report_mismatch("segment_first", segment_first, want.seg);
				if (beyond_limit !== want.over)
					report_mismatch("beyond_limit", beyond_limit, want.over);
				if (token_done !== want.done) report_mismatch("token_done", token_done, want.done);
				if (split_ok !== want.ok) report_mismatch("split_ok", split_ok, want.ok);
				if (want.over) saturated_seen++;
				if (want.ok) good_splits++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int len;
		int mode;
		int r;
		logic [31:0] base;

		// single-byte tokens first: their results can be written down directly
		append_row('{"A", 32'hFFFF_FFFF, 1'b1, 1'b1,
			'{8'h61, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0}});
		append_row('{8'hFF, 32'h0000_0000, 1'b1, 1'b1,
			'{8'hFF, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0}});
		append_row('{8'h00, 32'h5555_AAAA, 1'b1, 1'b1,
			'{8'h00, 32'h5555_AAAA, 1'b1, 1'b0, 1'b1, 1'b0}});
		append_row('{"z", 32'hAAAA_5555, 1'b1, 1'b1,
			'{"z", 32'hAAAA_5555, 1'b1, 1'b0, 1'b1, 1'b0}});
		// lower to upper change
		append_row('{"a", 32'd100, 1'b0, 1'b0, '{default: '0}});
		append_row('{"B", 32'd0, 1'b1, 1'b0, '{default: '0}});
		// upper followed by upper-then-lower, offset wraps past the top
		append_row('{"A", 32'hFFFF_FFFE, 1'b0, 1'b0, '{default: '0}});
		append_row('{"B", 32'd0, 1'b0, 1'b0, '{default: '0}});
		append_row('{"c", 32'd0, 1'b1, 1'b0, '{default: '0}});
		// two uppers at token end: no lookahead, no boundary
		append_row('{"A", 32'd7, 1'b0, 1'b0, '{default: '0}});
		append_row('{"B", 32'd0, 1'b1, 1'b0, '{default: '0}});
		// letter to digit, digit to letter
		append_row('{"a", 32'd20, 1'b0, 1'b0, '{default: '0}});
		append_row('{"1", 32'd0, 1'b1, 1'b0, '{default: '0}});
		append_row('{"9", 32'd30, 1'b0, 1'b0, '{default: '0}});
		append_row('{"z", 32'd0, 1'b1, 1'b0, '{default: '0}});
		// non-ASCII byte between a lower and an upper case letter: no boundary
		append_row('{"a", 32'd40, 1'b0, 1'b0, '{default: '0}});
		append_row('{8'h80, 32'd0, 1'b0, 1'b0, '{default: '0}});
		append_row('{"B", 32'd0, 1'b1, 1'b0, '{default: '0}});
		// upper then lower only: no boundary
		append_row('{"Z", 32'd50, 1'b0, 1'b0, '{default: '0}});
		append_row('{"z", 32'd0, 1'b1, 1'b0, '{default: '0}});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[i]) begin
			send_byte(stim_rows[i].b, stim_rows[i].base, stim_rows[i].last, stim_rows[i].typed,
				stim_rows[i].want);
			if (stim_rows[i].last) tokens_sent++;
		end

		// one long token up front so segment saturation can be reached
		send_token(300, 2, $urandom);
		while (bytes_in < TARGET_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 8) len = 1;
			else if (r < 97) len = $urandom_range(2, 12);
			else len = $urandom_range(257, 400);
			if (len > 256) mode = 2;
			else mode = ($urandom_range(0, 99) < 80) ? 0 : 1;
			base = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 15)
				: $urandom;
			send_token(len, mode, base);
		end
		in_valid = 1'b0;
		last_byte = 1'b0;
		row_typed = 1'b0;

		while (split_results_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d tokens, %0d bytes in, %0d results checked", tokens_sent, bytes_in,
			results_seen);
		$display("%0d results past the segment limit, %0d tokens with a valid split",
			saturated_seen, good_splits);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", fails);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
